// File: design/bpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// Sizes, request and response structs, store command structs, state codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_ORDER = 10;
   localparam int MAX_PAGES = 4096;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int CNT_W     = PAGE_W + 1;
   localparam int ORD_W     = 4;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);

   localparam logic [ORD_W-1:0] NOT_HEAD = 4'd15;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_MARK  = 2'd2;

   // First bitmap word of each order: order o holds MAX_PAGES >> o bits
   function automatic int map_base(input int o);
      int acc;
      int w;
      acc = 0;
      for (int k = 0; k < o; k++) begin
         w = MAX_PAGES >> (k + BIT_W);
         acc += (w < 1) ? 1 : w;
      end
      return acc;
   endfunction

   localparam int MAP_WORDS = map_base(MAX_ORDER + 1);
   localparam int MAP_AW    = $clog2(MAP_WORDS);

   typedef struct packed {
      logic [1:0]        op;
      logic [ORD_W-1:0]  order;
      logic [PAGE_W-1:0] page;
      logic [CNT_W-1:0]  count;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] result_page;
      logic              ok;
      logic [CNT_W-1:0]  free_count;
   } rsp_type;

   typedef struct packed {
      logic              clear;
      logic [MAP_AW-1:0] clr_addr;
      logic              we;
      logic [ORD_W-1:0]  ord;
      logic [PAGE_W-1:0] blk;
      logic [WORD_W-1:0] wdata;
   } map_cmd_type;

   typedef struct packed {
      logic              we;
      logic [PAGE_W-1:0] addr;
      logic [ORD_W-1:0]  wdata;
   } head_cmd_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DONE, S_SET_RD, S_SET_WR, S_MARK_STEP,
      S_AL_START, S_AL_CHECK, S_AL_TEST, S_AL_SPLIT, S_AL_HEAD,
      S_FR_START, S_FR_CHECK, S_FR_CLR, S_FR_MERGE, S_FR_RD, S_FR_TEST,
      S_FR_FINAL
   } state_type;

endpackage
`default_nettype wire

// File: design/bpa_map_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_map_mem: free bitmap store
// All orders packed into one word memory; maps (order, block) to a word.
// ----------------------------------------------------------------------------
module bpa_map_mem (
   input  wire                          clock,
   input  bpa_pkg::map_cmd_type         cmd,
   output logic [bpa_pkg::WORD_W-1:0]   rd_data
);
   import bpa_pkg::*;

   logic [WORD_W-1:0] mem [MAP_WORDS];
   logic [MAP_AW-1:0] base_tab [MAX_ORDER+1];
   logic [ORD_W-1:0]  ord_idx;
   logic [MAP_AW-1:0] addr;

   // Build the per-order base table
   always_comb begin
      for (int k = 0; k <= MAX_ORDER; k++) begin
         base_tab[k] = MAP_AW'(map_base(k));
      end
   end

   // Select word address
   always_comb begin
      ord_idx = (cmd.ord > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : cmd.ord;
      if (cmd.clear) begin
         addr = cmd.clr_addr;
      end else begin
         addr = base_tab[ord_idx] + MAP_AW'(cmd.blk >> BIT_W);
      end
   end

   // Write and registered read
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[addr] <= cmd.wdata;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

// File: design/bpa_head_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_head_mem: head order table
// One order code per page, registered read.
// ----------------------------------------------------------------------------
module bpa_head_mem (
   input  wire                         clock,
   input  bpa_pkg::head_cmd_type       cmd,
   output logic [bpa_pkg::ORD_W-1:0]   rd_data
);
   import bpa_pkg::*;

   logic [ORD_W-1:0] mem [MAX_PAGES];

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      rd_data <= mem[cmd.addr];
   end

endmodule
`default_nettype wire

// File: design/buddy_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator: buddy allocator over page indices
// Sequencer around a bitmap word store and a head order table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over both stores with busy high;
// csr writes are taken during it. A transaction is taken when start is high
// and busy low, and busy stays high until its response appears on rsp_data
// for exactly one cycle with rsp_valid; the receiver must take it then.
// Latency depends on the data and is set by the single-port stores: a region
// mark reads and writes one bitmap word per aligned block, an allocation
// scans bitmap words (up to 32 blocks a word), steps orders, reads and writes
// the bitmap per split and writes the head table per page of the block, and
// a free clears the head table per page of the block and reads and tests the
// bitmap per buddy merged.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  bpa_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output bpa_pkg::rsp_type               rsp_data,
   input  wire                            csr_we,
   input  wire [bpa_pkg::CNT_W-1:0]       csr_wdata
);
   import bpa_pkg::*;

   state_type          state_ff, state_in, ret_ff, ret_in;
   logic [ORD_W-1:0]   ord_ff, ord_in, o_ff, o_in;
   logic [PAGE_W-1:0]  page_ff, page_in, res_ff, res_in;
   logic [CNT_W-1:0]   end_ff, end_in, mp_ff, mp_in, blk_ff, blk_in, cnt_ff, cnt_in;
   logic [CNT_W-1:0]   free_ff, free_in, total_ff;
   logic [PAGE_W-1:0]  clr_ff;
   logic               ok_ff, ok_in;

   map_cmd_type        map_cmd;
   head_cmd_type       head_cmd;
   logic [WORD_W-1:0]  map_rd;
   logic [ORD_W-1:0]   head_rd;

   // Decision signals
   logic [CNT_W-1:0]   lim, n_blk, size_o, avail, rem, head_idx;
   logic [CNT_W:0]     add_sum, end_sum, fr_sum;
   logic [WORD_W-1:0]  mask, hits;
   logic [BIT_W-1:0]   hit_i;
   logic               hit, scan_done, al_bad, split_more, head_more;
   logic               mark_more, fr_bad, rec_bad, merge_go, buddy_free;
   logic [ORD_W-1:0]   tz, msb, fit, no;
   logic [PAGE_W-1:0]  buddy;
   logic [CNT_W-1:0]   hit_blk;

   bpa_map_mem u_map (
      .clock   (clock),
      .cmd     (map_cmd),
      .rd_data (map_rd)
   );

   bpa_head_mem u_head (
      .clock   (clock),
      .cmd     (head_cmd),
      .rd_data (head_rd)
   );

   // Shared arithmetic and compares
   always_comb begin
      lim = (total_ff > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_ff;
      n_blk = lim >> o_ff;
      size_o = CNT_W'(1) << o_ff;
      // Mark: largest aligned block at mp_ff within the region
      mark_more = mp_ff < end_ff;
      rem = end_ff - mp_ff;
      tz = ORD_W'(MAX_ORDER);
      for (int i = MAX_ORDER - 1; i >= 0; i--) begin
         if (mp_ff[i]) begin
            tz = ORD_W'(i);
         end
      end
      msb = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (rem[i]) begin
            msb = ORD_W'(i);
         end
      end
      fit = (tz < msb) ? tz : msb;
      if (fit > ORD_W'(MAX_ORDER)) begin
         fit = ORD_W'(MAX_ORDER);
      end
      add_sum = {1'b0, free_ff} + {1'b0, CNT_W'(1) << fit};
      // Allocate: scan of one bitmap word
      al_bad = ord_ff > ORD_W'(MAX_ORDER);
      scan_done = blk_ff >= n_blk;
      avail = n_blk - blk_ff;
      if (avail >= CNT_W'(WORD_W)) begin
         mask = '1;
      end else begin
         mask = (WORD_W'(1) << avail[BIT_W-1:0]) - WORD_W'(1);
      end
      hits = map_rd & mask;
      hit = |hits;
      hit_i = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (hits[i]) begin
            hit_i = BIT_W'(i);
         end
      end
      hit_blk = blk_ff + CNT_W'(hit_i);
      split_more = o_ff > ord_ff;
      no = o_ff - ORD_W'(1);
      head_idx = {1'b0, page_ff} + cnt_ff;
      head_more = (cnt_ff < size_o) && (head_idx < lim);
      // Free: head check and buddy merge
      fr_bad = {1'b0, page_ff} >= lim;
      rec_bad = (head_rd == NOT_HEAD) || (head_rd > ORD_W'(MAX_ORDER));
      fr_sum = {1'b0, free_ff} + {1'b0, CNT_W'(1) << head_rd};
      buddy = page_ff ^ PAGE_W'(size_o);
      merge_go = (o_ff < ORD_W'(MAX_ORDER)) && ({1'b0, buddy} < lim);
      buddy_free = map_rd[blk_ff[BIT_W-1:0]];
      end_sum = {2'b00, req_data.page} + {1'b0, req_data.count};
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == PAGE_W'(MAX_PAGES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_data.op)
                  OP_ALLOC: state_in = S_AL_START;
                  OP_FREE:  state_in = S_FR_START;
                  OP_MARK:  state_in = S_MARK_STEP;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_DONE:      state_in = S_IDLE;
         S_SET_RD:    state_in = S_SET_WR;
         S_SET_WR:    state_in = ret_ff;
         S_MARK_STEP: state_in = mark_more ? S_SET_RD : S_DONE;
         S_AL_START:  state_in = al_bad ? S_DONE : S_AL_CHECK;
         S_AL_CHECK: begin
            if (!scan_done) state_in = S_AL_TEST;
            else if (o_ff == ORD_W'(MAX_ORDER)) state_in = S_DONE;
         end
         S_AL_TEST:   state_in = hit ? S_AL_SPLIT : S_AL_CHECK;
         S_AL_SPLIT:  state_in = split_more ? S_SET_RD : S_AL_HEAD;
         S_AL_HEAD:   state_in = head_more ? S_AL_HEAD : S_DONE;
         S_FR_START:  state_in = fr_bad ? S_DONE : S_FR_CHECK;
         S_FR_CHECK:  state_in = rec_bad ? S_DONE : S_FR_CLR;
         S_FR_CLR:    state_in = head_more ? S_FR_CLR : S_FR_MERGE;
         S_FR_MERGE:  state_in = merge_go ? S_FR_RD : S_FR_FINAL;
         S_FR_RD:     state_in = S_FR_TEST;
         S_FR_TEST:   state_in = buddy_free ? S_FR_MERGE : S_FR_FINAL;
         S_FR_FINAL:  state_in = S_SET_RD;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath and store commands
   always_comb begin
      ret_in  = ret_ff;
      ord_in  = ord_ff;
      o_in    = o_ff;
      page_in = page_ff;
      end_in  = end_ff;
      mp_in   = mp_ff;
      blk_in  = blk_ff;
      cnt_in  = cnt_ff;
      free_in = free_ff;
      ok_in   = ok_ff;
      res_in  = res_ff;

      map_cmd.clear    = 1'b0;
      map_cmd.clr_addr = clr_ff[MAP_AW-1:0];
      map_cmd.we       = 1'b0;
      map_cmd.ord      = o_ff;
      map_cmd.blk      = blk_ff[PAGE_W-1:0];
      map_cmd.wdata    = map_rd;

      head_cmd.we    = 1'b0;
      head_cmd.addr  = head_idx[PAGE_W-1:0];
      head_cmd.wdata = NOT_HEAD;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep both stores to their empty values
            map_cmd.clear = 1'b1;
            map_cmd.we    = {1'b0, clr_ff} < CNT_W'(MAP_WORDS);
            map_cmd.wdata = '0;
            head_cmd.we   = 1'b1;
            head_cmd.addr = clr_ff;
         end
         S_IDLE: begin
            // Latch the request
            ord_in  = req_data.order;
            o_in    = req_data.order;
            page_in = req_data.page;
            mp_in   = {1'b0, req_data.page};
            end_in  = (end_sum > {1'b0, lim}) ? lim : end_sum[CNT_W-1:0];
            blk_in  = '0;
            cnt_in  = '0;
            ok_in   = 1'b0;
            res_in  = '0;
         end
         S_DONE: begin
         end
         S_SET_RD: begin
         end
         S_SET_WR: begin
            // Set the addressed bit
            map_cmd.we = 1'b1;
            map_cmd.wdata = map_rd | (WORD_W'(1) << blk_ff[BIT_W-1:0]);
         end
         S_MARK_STEP: begin
            if (mark_more) begin
               o_in    = fit;
               blk_in  = mp_ff >> fit;
               mp_in   = mp_ff + (CNT_W'(1) << fit);
               free_in = (add_sum > {1'b0, lim}) ? lim : add_sum[CNT_W-1:0];
               ret_in  = S_MARK_STEP;
            end else begin
               ok_in = 1'b1;
            end
         end
         S_AL_START: begin
         end
         S_AL_CHECK: begin
            // Advance to the next order when this one is exhausted
            if (scan_done && (o_ff != ORD_W'(MAX_ORDER))) begin
               o_in   = o_ff + ORD_W'(1);
               blk_in = '0;
            end
         end
         S_AL_TEST: begin
            if (hit) begin
               map_cmd.we    = 1'b1;
               map_cmd.wdata = map_rd & ~(WORD_W'(1) << hit_i);
               blk_in        = hit_blk;
               page_in       = PAGE_W'(hit_blk << o_ff);
            end else begin
               blk_in = blk_ff + CNT_W'(WORD_W);
            end
         end
         S_AL_SPLIT: begin
            // Free the upper half one order down, or finish the split
            if (split_more) begin
               o_in   = no;
               blk_in = ({1'b0, page_ff} >> no) + CNT_W'(1);
               ret_in = S_AL_SPLIT;
            end else begin
               free_in = (free_ff >= size_o) ? free_ff - size_o : '0;
               cnt_in  = '0;
            end
         end
         S_AL_HEAD: begin
            if (head_more) begin
               head_cmd.we    = 1'b1;
               head_cmd.wdata = (cnt_ff == '0) ? ord_ff : NOT_HEAD;
               cnt_in         = cnt_ff + CNT_W'(1);
            end else begin
               ok_in  = 1'b1;
               res_in = page_ff;
            end
         end
         S_FR_START: begin
         end
         S_FR_CHECK: begin
            if (!rec_bad) begin
               o_in    = head_rd;
               free_in = (fr_sum > {1'b0, lim}) ? lim : fr_sum[CNT_W-1:0];
            end
         end
         S_FR_CLR: begin
            if (head_more) begin
               head_cmd.we = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
         end
         S_FR_MERGE: begin
            blk_in = {1'b0, buddy} >> o_ff;
         end
         S_FR_RD: begin
         end
         S_FR_TEST: begin
            // Take the free buddy out and climb one order
            if (buddy_free) begin
               map_cmd.we    = 1'b1;
               map_cmd.wdata = map_rd & ~(WORD_W'(1) << blk_ff[BIT_W-1:0]);
               page_in       = (buddy < page_ff) ? buddy : page_ff;
               o_in          = o_ff + ORD_W'(1);
            end
         end
         S_FR_FINAL: begin
            blk_in = {1'b0, page_ff} >> o_ff;
            ok_in  = 1'b1;
            ret_in = S_DONE;
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         free_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= (state_ff == S_CLEAR) ? clr_ff + PAGE_W'(1) : clr_ff;
         free_ff  <= free_in;
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
      end
      ret_ff  <= ret_in;
      ord_ff  <= ord_in;
      o_ff    <= o_in;
      page_ff <= page_in;
      end_ff  <= end_in;
      mp_ff   <= mp_in;
      blk_ff  <= blk_in;
      cnt_ff  <= cnt_in;
      ok_ff   <= ok_in;
      res_ff  <= res_in;
   end

   // Outputs
   always_comb begin
      busy = state_ff != S_IDLE;
      rsp_valid = state_ff == S_DONE;
      rsp_data.result_page = res_ff;
      rsp_data.ok = ok_ff;
      rsp_data.free_count = free_ff;
   end

endmodule
`default_nettype wire

// File: test/buddy_page_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb: self-checking bench for the buddy page allocator
// Drives allocate, free, region-mark and no-op transactions under several
// page totals, predicts every response with a bit-accurate shadow of the
// bitmaps, head table and free count, and checks each response in order.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int DRAIN_WAIT  = 200;

   typedef enum logic [1:0] {ITEM_REQ, ITEM_CSR, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type     kind;
      req_type           req;
      logic [CNT_W-1:0]  total;
      bit                calm;
   } item_type;

   typedef struct {
      rsp_type rsp;
      int      stamp;
   } expect_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   item_type   pending_q[$];
   expect_type alloc_rsp_q[$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         gap_left = 0;

   // shadow allocator state
   bit         shadow_free[0:MAX_ORDER][0:MAX_PAGES-1];
   logic [3:0] shadow_head[0:MAX_PAGES-1];
   int         shadow_free_pages = 0;
   int         shadow_total = 0;

   buddy_page_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("buddy_page_allocator verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // shadow allocator
   // ---------------------------------------------------------------------
   function automatic int pages_in_use();
      return (shadow_total > MAX_PAGES) ? MAX_PAGES : shadow_total;
   endfunction

   function automatic void credit_pages(int n);
      shadow_free_pages += n;
      if (shadow_free_pages > pages_in_use())
         shadow_free_pages = pages_in_use();
   endfunction

   function automatic void mark_range(int base, int n);
      int stop;
      int p;
      int o;
      stop = base + n;
      if (stop > pages_in_use())
         stop = pages_in_use();
      p = base;
      while (p < stop) begin
         // grow the block while aligned and still inside the range
         o = 0;
         while (o < MAX_ORDER && (p & ((1 << (o + 1)) - 1)) == 0
                && (stop - p) >= (1 << (o + 1)))
            o++;
         shadow_free[o][p >> o] = 1'b1;
         credit_pages(1 << o);
         p += 1 << o;
      end
   endfunction

   function automatic bit take_block(int want, output int head);
      int o;
      int blk;
      int span;
      bit found;
      head = 0;
      if (want > MAX_ORDER)
         return 1'b0;
      found = 1'b0;
      blk = 0;
      o = want;
      while (o <= MAX_ORDER && !found) begin
         for (int b = 0; b < (pages_in_use() >> o); b++) begin
            if (shadow_free[o][b]) begin
               blk = b;
               found = 1'b1;
               break;
            end
         end
         if (!found)
            o++;
      end
      if (!found)
         return 1'b0;
      shadow_free[o][blk] = 1'b0;
      head = blk << o;
      // split down, releasing each upper half
      while (o > want) begin
         o--;
         shadow_free[o][(head + (1 << o)) >> o] = 1'b1;
      end
      span = 1 << want;
      shadow_head[head] = want[3:0];
      for (int i = 1; i < span && head + i < pages_in_use(); i++)
         shadow_head[head + i] = NOT_HEAD;
      shadow_free_pages = (shadow_free_pages >= span) ? shadow_free_pages - span : 0;
      return 1'b1;
   endfunction

   function automatic bit return_block(int head);
      int o;
      int buddy;
      if (head >= pages_in_use())
         return 1'b0;
      o = shadow_head[head];
      if (o == NOT_HEAD || o > MAX_ORDER)
         return 1'b0;
      credit_pages(1 << o);
      for (int i = 0; i < (1 << o) && head + i < pages_in_use(); i++)
         shadow_head[head + i] = NOT_HEAD;
      // merge with free buddies upward
      while (o < MAX_ORDER) begin
         buddy = head ^ (1 << o);
         if (buddy >= pages_in_use() || !shadow_free[o][buddy >> o])
            break;
         shadow_free[o][buddy >> o] = 1'b0;
         if (buddy < head)
            head = buddy;
         o++;
      end
      shadow_free[o][head >> o] = 1'b1;
      return 1'b1;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type res;
      int head;
      res = '0;
      head = 0;
      case (r.op)
         OP_ALLOC: begin
            res.ok = take_block(int'(r.order), head);
            res.result_page = res.ok ? head[PAGE_W-1:0] : '0;
         end
         OP_FREE: res.ok = return_block(int'(r.page));
         OP_MARK: begin
            mark_range(int'(r.page), int'(r.count));
            res.ok = 1'b1;
         end
         default: res.ok = 1'b0;
      endcase
      res.free_count = shadow_free_pages[CNT_W-1:0];
      return res;
   endfunction

   initial begin
      foreach (shadow_free[o, b])
         shadow_free[o][b] = 1'b0;
      foreach (shadow_head[i])
         shadow_head[i] = NOT_HEAD;
   end

   // ---------------------------------------------------------------------
   // driver: hold start until taken, apply csr writes only when drained
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit taken;
      bit next_start;
      bit next_we;
      expect_type e;
      item_type it;
      taken = start && !busy;
      next_start = start && !taken;
      next_we = 1'b0;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (taken) begin
            e.rsp = predict_rsp(req_data);
            e.stamp = cycle_count;
            alloc_rsp_q.push_back(e);
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0) begin
               it = pending_q[0];
               case (it.kind)
                  ITEM_REQ: begin
                     pending_q.pop_front();
                     req_data <= it.req;
                     next_start = 1'b1;
                     if (!it.calm && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 10);
                  end
                  ITEM_CSR: begin
                     if (alloc_rsp_q.size() == 0 && !busy) begin
                        pending_q.pop_front();
                        csr_wdata <= it.total;
                        next_we = 1'b1;
                        shadow_total = int'(it.total);
                     end
                  end
                  default: begin
                     if (alloc_rsp_q.size() == 0 && !busy)
                        pending_q.pop_front();
                  end
               endcase
            end
         end
      end
      start <= next_start;
      csr_we <= next_we;
   end

   // ---------------------------------------------------------------------
   // monitor: check each response against the oldest prediction
   // ---------------------------------------------------------------------
   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      expect_type e;
      if (!reset && rsp_valid) begin
         if (alloc_rsp_q.size() == 0 || alloc_rsp_q[0].stamp == cycle_count) begin
            report("unexpected response page", int'(rsp_data.result_page), -1);
         end else begin
            e = alloc_rsp_q.pop_front();
            if (rsp_data.result_page !== e.rsp.result_page)
               report("result_page", int'(rsp_data.result_page), int'(e.rsp.result_page));
            if (rsp_data.ok !== e.rsp.ok)
               report("ok", int'(rsp_data.ok), int'(e.rsp.ok));
            if (rsp_data.free_count !== e.rsp.free_count)
               report("free_count", int'(rsp_data.free_count), int'(e.rsp.free_count));
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic void add_req(logic [1:0] op, int ord, int pg, int n, bit calm);
      item_type it;
      it.kind = ITEM_REQ;
      it.req.op = op;
      it.req.order = ord[ORD_W-1:0];
      it.req.page = pg[PAGE_W-1:0];
      it.req.count = n[CNT_W-1:0];
      it.total = '0;
      it.calm = calm;
      pending_q.push_back(it);
   endfunction

   function automatic void set_total(int tp);
      item_type it;
      it.kind = ITEM_DRAIN;
      it.req = '0;
      it.total = '0;
      it.calm = 1'b0;
      pending_q.push_back(it);
      it.kind = ITEM_CSR;
      it.total = tp[CNT_W-1:0];
      pending_q.push_back(it);
   endfunction

   function automatic void add_random(int tp, bit calm);
      int pick;
      int ord;
      int top;
      int lim;
      lim = (tp > MAX_PAGES) ? MAX_PAGES : tp;
      top = (lim > 0) ? lim - 1 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // mostly small orders keep latency down
         ord = $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0)
            ord = $urandom_range(0, MAX_ORDER);
         if ($urandom_range(0, 19) == 0)
            ord = $urandom_range(MAX_ORDER + 1, 15);
         add_req(OP_ALLOC, ord, $urandom_range(0, 4095), $urandom_range(0, 4096), calm);
      end else if (pick < 80) begin
         ord = $urandom_range(0, 4);
         add_req(OP_FREE, $urandom_range(0, 15),
                 ($urandom_range(0, top) >> ord) << ord, $urandom_range(0, 4096), calm);
      end else if (pick < 95) begin
         add_req(OP_MARK, $urandom_range(0, 15),
                 (pick < 93) ? $urandom_range(0, top) : $urandom_range(0, 4095),
                 (pick < 90) ? $urandom_range(0, 40) : $urandom_range(0, 4096), calm);
      end else begin
         add_req(2'd3, $urandom_range(0, 15), $urandom_range(0, 4095),
                 $urandom_range(0, 4096), calm);
      end
   endfunction

   initial begin
      int totals[] = '{37, 64, 1, 2, 100, 256, 13, 512, 1024, 4096, 200, 8191, 64};
      int counts[] = '{150, 150, 60, 80, 150, 150, 100, 150, 120, 40, 150, 30, 150};
      int left;

      // empty allocator: nothing can be allocated or freed
      add_req(OP_ALLOC, 0, 0, 0, 1'b0);
      add_req(OP_FREE, 0, 0, 0, 1'b0);
      add_req(OP_MARK, 0, 0, 5, 1'b0);
      add_req(2'd3, 15, 4095, 4096, 1'b0);
      set_total(0);
      add_req(OP_MARK, 0, 0, 4096, 1'b0);
      // full range, largest block, oversized orders, split and merge
      set_total(4096);
      add_req(OP_MARK, 0, 0, 4096, 1'b0);
      add_req(OP_ALLOC, MAX_ORDER, 0, 0, 1'b0);
      add_req(OP_ALLOC, 15, 0, 0, 1'b0);
      add_req(OP_ALLOC, MAX_ORDER + 1, 0, 0, 1'b0);
      add_req(OP_ALLOC, 0, 0, 0, 1'b0);
      add_req(OP_FREE, 0, 4095, 0, 1'b0);
      add_req(OP_FREE, 0, 0, 0, 1'b0);
      add_req(OP_FREE, 0, 1024, 0, 1'b0);
      add_req(OP_FREE, 0, 1024, 0, 1'b0);
      add_req(OP_MARK, 0, 4095, 4096, 1'b0);
      // shrink with state kept, then free past the end and clip a region
      set_total(100);
      add_req(OP_ALLOC, 2, 0, 0, 1'b0);
      add_req(OP_FREE, 0, 100, 0, 1'b0);
      add_req(OP_MARK, 0, 90, 20, 1'b0);
      add_req(OP_MARK, 0, 4000, 10, 1'b0);
      add_req(OP_ALLOC, 6, 0, 0, 1'b0);

      // random phases, each seeded with a fully free range
      foreach (totals[k]) begin
         set_total(totals[k]);
         add_req(OP_MARK, 0, 0, totals[k], 1'b0);
         for (int i = 0; i < counts[k]; i++) begin
            left = (k == totals.size() - 1) ? counts[k] - i : 1000;
            add_random(totals[k], left <= 100);
            if ($urandom_range(0, 29) == 0)
               add_req(OP_MARK, 0, $urandom_range(0, totals[k]), $urandom_range(1, 64),
                       left <= 100);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || alloc_rsp_q.size() > 0 || start)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && alloc_rsp_q.size() == 0)
         $display("buddy_page_allocator verification clean");
      else
         $display("buddy_page_allocator verification failed");
      $finish;
   end

endmodule
